[rtl/smpq_pkg.sv]
package smpq_pkg;

  // Store geometry.
  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int OP_BITS    = 2;
  localparam int STAT_BITS  = 2;

  // Operation codes.
  localparam logic [OP_BITS-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POP  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_PEEK = 2'd2;

  // Status codes.
  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;

  // Input word.
  typedef struct packed {
    logic [OP_BITS-1:0]           operation;
    logic signed [KEY_BITS-1:0]   entry_key;
    logic [VALUE_BITS-1:0]        entry_value;
  } smpq_in_t;

  // Result word.
  typedef struct packed {
    logic [VALUE_BITS-1:0]        out_value;
    logic signed [KEY_BITS-1:0]   out_key;
    logic                         out_valid;
    logic [COUNT_BITS-1:0]        element_count;
    logic [STAT_BITS-1:0]         status;
  } smpq_out_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                         push;
    logic                         pop;
    logic signed [KEY_BITS-1:0]   new_key;
    logic [VALUE_BITS-1:0]        new_value;
  } smpq_cmd_t;

endpackage

[rtl/stable_max_priority_queue.sv]
// Stable bounded max-priority queue. Entries sit in a row of cells in
// serving order, cell 0 holding the oldest entry of the highest key. Every
// cell compares its key with a pushed key in the same cycle, so the block
// accepts one word per clock while the output register is free or being
// read; the compare and the shift select across the cell row are combinational.
// Each accepted word yields one result word in the output register on the
// next cycle, and a new word is taken while that result is being read.
// Push to a full queue is dropped with status full; pop or peek on an empty
// queue returns status empty with out_valid low. No clearing pass follows
// reset: occupancy comes from the element count.
module stable_max_priority_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  smpq_pkg::smpq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output smpq_pkg::smpq_out_t out_data_o
);

  localparam int N = smpq_pkg::CAPACITY;

  logic [smpq_pkg::COUNT_BITS-1:0]      count_q, count_d;
  logic                                 res_valid_q;
  smpq_pkg::smpq_out_t                  res_q, res_d;
  smpq_pkg::smpq_cmd_t                  cmd;
  logic                                 in_fire;
  logic                                 full, empty;

  logic                                 occ  [N];
  logic                                 keep [N];
  logic signed [smpq_pkg::KEY_BITS-1:0] key  [N];
  logic [smpq_pkg::VALUE_BITS-1:0]      val  [N];

  // A new word is taken whenever the output register frees up this cycle.
  assign in_ready_o = !res_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign full  = (count_q == smpq_pkg::COUNT_BITS'(N));
  assign empty = (count_q == '0);

  // Decode the word into a row command and the result.
  always_comb begin
    cmd.push      = 1'b0;
    cmd.pop       = 1'b0;
    cmd.new_key   = in_data_i.entry_key;
    cmd.new_value = in_data_i.entry_value;
    count_d       = count_q;
    res_d.out_value = '0;
    res_d.out_key   = '0;
    res_d.out_valid = 1'b0;
    res_d.status    = smpq_pkg::ST_OK;
    case (in_data_i.operation)
      smpq_pkg::OP_PUSH: begin
        if (full) begin
          res_d.status = smpq_pkg::ST_FULL;
        end else begin
          cmd.push = in_fire;
          count_d  = count_q + 1'b1;
        end
      end
      smpq_pkg::OP_POP, smpq_pkg::OP_PEEK: begin
        if (empty) begin
          res_d.status = smpq_pkg::ST_EMPTY;
        end else begin
          res_d.out_value = val[0];
          res_d.out_key   = key[0];
          res_d.out_valid = 1'b1;
          if (in_data_i.operation == smpq_pkg::OP_POP) begin
            cmd.pop = in_fire;
            count_d = count_q - 1'b1;
          end
        end
      end
      default: begin
        // Unused code: no change to the store.
      end
    endcase
    res_d.element_count = count_d;
  end

  // The row of cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                                 prev_keep;
    logic signed [smpq_pkg::KEY_BITS-1:0] left_key, right_key;
    logic [smpq_pkg::VALUE_BITS-1:0]      left_val, right_val;

    assign occ[i] = (smpq_pkg::COUNT_BITS'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign left_key  = cmd.new_key;
      assign left_val  = cmd.new_value;
    end else begin : g_body
      assign prev_keep = keep[i-1];
      assign left_key  = key[i-1];
      assign left_val  = val[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_key = '0;
      assign right_val = '0;
    end else begin : g_mid
      assign right_key = key[i+1];
      assign right_val = val[i+1];
    end

    smpq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (occ[i]),
      .prev_keep_i   (prev_keep),
      .left_key_i    (left_key),
      .left_value_i  (left_val),
      .right_key_i   (right_key),
      .right_value_i (right_val),
      .keep_o        (keep[i]),
      .key_o         (key[i]),
      .value_o       (val[i])
    );
  end

  // Element count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

[rtl/smpq_cell.sv]
module smpq_cell (
  input  logic                                 clk_i,
  input  smpq_pkg::smpq_cmd_t                  cmd_i,
  input  logic                                 occupied_i,
  input  logic                                 prev_keep_i,
  input  logic signed [smpq_pkg::KEY_BITS-1:0] left_key_i,
  input  logic [smpq_pkg::VALUE_BITS-1:0]      left_value_i,
  input  logic signed [smpq_pkg::KEY_BITS-1:0] right_key_i,
  input  logic [smpq_pkg::VALUE_BITS-1:0]      right_value_i,
  output logic                                 keep_o,
  output logic signed [smpq_pkg::KEY_BITS-1:0] key_o,
  output logic [smpq_pkg::VALUE_BITS-1:0]      value_o
);

  logic signed [smpq_pkg::KEY_BITS-1:0] key_q, key_d;
  logic [smpq_pkg::VALUE_BITS-1:0]      value_q, value_d;

  // A stored entry of equal or higher key stays ahead of a new one.
  assign keep_o = occupied_i && (key_q >= cmd_i.new_key);

  // Push: hold, take the new entry at the insertion point, or shift right.
  // Pop: every cell takes its right neighbor.
  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (cmd_i.push) begin
      if (!keep_o) begin
        if (prev_keep_i) begin
          key_d   = cmd_i.new_key;
          value_d = cmd_i.new_value;
        end else begin
          key_d   = left_key_i;
          value_d = left_value_i;
        end
      end
    end else if (cmd_i.pop) begin
      key_d   = right_key_i;
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

[rtl/smpq_checker.sv]
module smpq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input smpq_pkg::smpq_out_t out_data_o
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Every accepted word gives a result word on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after an accepted word");

  // A dropped push only happens at full capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == smpq_pkg::ST_FULL |->
      out_data_o.element_count == smpq_pkg::COUNT_BITS'(smpq_pkg::CAPACITY))
    else $error("full status with free room");

  // An empty status reports an empty store and carries no entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == smpq_pkg::ST_EMPTY |->
      out_data_o.element_count == '0 && !out_data_o.out_valid)
    else $error("empty status with stored entries");

  // A returned entry always comes with status ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_valid |-> out_data_o.status == smpq_pkg::ST_OK)
    else $error("entry returned with error status");

endmodule

bind stable_max_priority_queue smpq_checker u_smpq_checker (.*);
